>>> rtl/core/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
package stbs_pkg;

   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic search_start;
      logic probe_step;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_empty;
      logic hit;
      logic stop;
   } dp_status_type;

endpackage

>>> rtl/core/sorted_table_binary_search.sv
// sorted table binary search: table loads and searches over an ascending range
//
// req channel: req_cmd selects a load (writes req_entry_value at req_entry_index,
// no response; indexes at or beyond DEPTH are dropped) or a search for req_target
// between req_lower_bound and req_upper_bound inclusive, bounds clamped to DEPTH-1.
// rsp channel: one item per search with rsp_found and rsp_position (0 if not found).
// A search starts, then probes the table (one table read and compare per cycle,
// at most clog2(DEPTH)+1 probes), then moves the result into the output register;
// the probe loop runs on the single table read port.
// req_stall is high while a search is running or its result waits to be moved.
// The output register lets the next item be taken while a result is still held;
// a stalled rsp holds its payload, and a finished search waits until it clears.
// Reset clears the sequencer and the rsp valid; table contents are kept and are
// undefined until loaded, so a search must only cover loaded entries.
module sorted_table_binary_search #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [stbs_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]  req_entry_value,
   input  logic [stbs_pkg::IDX_W-1:0]          req_lower_bound,
   input  logic [stbs_pkg::IDX_W-1:0]          req_upper_bound,
   input  logic signed [stbs_pkg::DATA_W-1:0]  req_target,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [stbs_pkg::IDX_W-1:0]          rsp_position
);

   stbs_pkg::dp_cmd_type    cmd;
   stbs_pkg::dp_status_type status;
   stbs_pkg::cmd_type       req_cmd_code;

   assign req_cmd_code = stbs_pkg::cmd_type'(req_cmd);

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd_code),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   stbs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_lower_bound (req_lower_bound),
      .req_upper_bound (req_upper_bound),
      .req_target      (req_target),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule

>>> rtl/core/stbs_datapath.sv
// table memory, search bounds, probe compare and result registers
module stbs_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  stbs_pkg::dp_cmd_type                cmd,
   output stbs_pkg::dp_status_type             status,
   input  logic [stbs_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]  req_entry_value,
   input  logic [stbs_pkg::IDX_W-1:0]          req_lower_bound,
   input  logic [stbs_pkg::IDX_W-1:0]          req_upper_bound,
   input  logic signed [stbs_pkg::DATA_W-1:0]  req_target,
   output logic                                rsp_found,
   output logic [stbs_pkg::IDX_W-1:0]          rsp_position
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW = (AW > stbs_pkg::IDX_W) ? AW : stbs_pkg::IDX_W;
   localparam logic [BW-1:0] LAST_IDX = BW'(DEPTH - 1);

   logic signed [stbs_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [stbs_pkg::DATA_W-1:0] target_ff;
   logic [AW-1:0] lo_ff, hi_ff, mid_ff;
   logic [AW-1:0] lo_in, hi_in, mid_in;
   logic          res_found_ff;
   logic [AW-1:0] res_pos_ff;
   logic [AW-1:0] rd_addr;

   logic [BW-1:0] widx_ext, lb_ext, ub_ext, pos_ext;
   logic [AW-1:0] clo, chi, mid0;
   logic          greater;

   assign widx_ext = BW'(req_entry_index);
   assign lb_ext   = BW'(req_lower_bound);
   assign ub_ext   = BW'(req_upper_bound);

   // clamp the bounds to the last table entry
   assign clo  = (lb_ext > LAST_IDX) ? AW'(LAST_IDX) : lb_ext[AW-1:0];
   assign chi  = (ub_ext > LAST_IDX) ? AW'(LAST_IDX) : ub_ext[AW-1:0];
   assign mid0 = clo + ((chi - clo) >> 1);

   // rd_data_ff holds the entry at mid_ff during a probe
   assign greater = rd_data_ff > target_ff;

   always_comb begin
      if (greater) begin
         lo_in = lo_ff;
         hi_in = mid_ff - AW'(1);
      end else begin
         lo_in = mid_ff + AW'(1);
         hi_in = hi_ff;
      end
      mid_in = lo_in + ((hi_in - lo_in) >> 1);
   end

   assign status.range_empty = clo > chi;
   assign status.hit         = rd_data_ff == target_ff;
   // the next range is empty when the probe sat on the bound it moves past
   assign status.stop        = greater ? (mid_ff == lo_ff) : (mid_ff == hi_ff);

   assign rd_addr = cmd.search_start ? mid0 : mid_in;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && (widx_ext <= LAST_IDX)) begin
         mem[widx_ext[AW-1:0]] <= req_entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         lo_ff        <= clo;
         hi_ff        <= chi;
         mid_ff       <= mid0;
         target_ff    <= req_target;
         res_found_ff <= 1'b0;
         res_pos_ff   <= '0;
      end else if (cmd.probe_step) begin
         if (status.hit) begin
            res_found_ff <= 1'b1;
            res_pos_ff   <= mid_ff;
         end else begin
            lo_ff  <= lo_in;
            hi_ff  <= hi_in;
            mid_ff <= mid_in;
         end
      end
      if (cmd.out_load) begin
         rsp_found    <= res_found_ff;
         rsp_position <= pos_ext[stbs_pkg::IDX_W-1:0];
      end
   end

   assign pos_ext = BW'(res_pos_ff);

endmodule

>>> rtl/core/stbs_ctrl.sv
// search sequencer and result valid register
module stbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  stbs_pkg::cmd_type       req_cmd,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output stbs_pkg::dp_cmd_type    cmd,
   input  stbs_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take, out_free;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == stbs_pkg::CMD_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.search_start = 1'b1;
                  state_in = status.range_empty ? ST_DONE : ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            cmd.probe_step = 1'b1;
            if (status.hit || status.stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> verif/sorted_table_binary_search_tb.sv
// testbench for the sorted table binary search block: table loads and searches checked
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;

   localparam int DEPTH       = 1024;
   localparam int ITEM_BUDGET = 1800;
   localparam int MAX_SHOWN   = 10;

   typedef logic signed [stbs_pkg::DATA_W-1:0] word_type;
   typedef logic [stbs_pkg::IDX_W-1:0]         index_type;

   typedef struct packed {
      logic      found;
      index_type position;
   } lookup_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_cmd;
   index_type req_entry_index;
   word_type  req_entry_value;
   index_type req_lower_bound;
   index_type req_upper_bound;
   word_type  req_target;
   logic      rsp_valid;
   logic      rsp_stall;
   logic      rsp_found;
   index_type rsp_position;

   // shadow copy of the table and which entries have been loaded
   word_type   shadow_words [0:DEPTH-1];
   bit         loaded       [0:DEPTH-1];
   word_type   fresh_words  [0:DEPTH-1];
   lookup_type pending_lookups[$];

   int items_sent;
   int mismatches;
   bit req_idle_on;
   bit rsp_idle_on;
   int pressure_cycles;

   sorted_table_binary_search #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_lower_bound(req_lower_bound),
      .req_upper_bound(req_upper_bound),
      .req_target     (req_target),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic index_type rand_index();
      logic [31:0] r;
      r = $urandom;
      return r[stbs_pkg::IDX_W-1:0];
   endfunction

   function automatic word_type rand_word();
      word_type w;
      w = $urandom;
      return w;
   endfunction

   // walk the probe path; also flags a probe that lands on a never-loaded entry
   function automatic lookup_type predict_lookup(input index_type lower_b,
         input index_type upper_b, input word_type want,
         output bit touches_unloaded);
      int         lo;
      int         hi;
      int         mid;
      lookup_type res;
      lo = int'(lower_b);
      hi = int'(upper_b);
      if (lo > DEPTH - 1) lo = DEPTH - 1;
      if (hi > DEPTH - 1) hi = DEPTH - 1;
      res = '0;
      touches_unloaded = 1'b0;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (!loaded[mid]) touches_unloaded = 1'b1;
         if (shadow_words[mid] == want) begin
            res.found    = 1'b1;
            res.position = index_type'(mid);
            break;
         end
         if (shadow_words[mid] > want) hi = mid - 1;
         else lo = mid + 1;
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input int expected, input int actual);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, expected, actual);
   endtask

   task automatic send_item(input stbs_pkg::cmd_type cmd, input index_type index,
         input word_type value, input index_type lower_b,
         input index_type upper_b, input word_type want);
      int         gap;
      bit         unloaded_hit;
      lookup_type predicted;
      gap = req_idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_entry_index <= index;
      req_entry_value <= value;
      req_lower_bound <= lower_b;
      req_upper_bound <= upper_b;
      req_target      <= want;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (cmd == stbs_pkg::CMD_LOAD) begin
         shadow_words[index] = value;
         loaded[index]       = 1'b1;
      end else begin
         predicted = predict_lookup(lower_b, upper_b, want, unloaded_hit);
         pending_lookups.insert(pending_lookups.size(), predicted);
      end
   endtask

   // unused fields carry random values
   task automatic send_load(input index_type index, input word_type value);
      send_item(stbs_pkg::CMD_LOAD, index, value, rand_index(), rand_index(), rand_word());
   endtask

   task automatic send_search(input index_type lower_b,
         input index_type upper_b, input word_type want);
      send_item(stbs_pkg::CMD_SEARCH, rand_index(), rand_word(), lower_b, upper_b, want);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // load a region, then search it; searches may stray outside when every probe is loaded
   task automatic run_session(input int base, input int span, input bit sorted,
         input int n_searches);
      int         i;
      int         j;
      int         k;
      int         lo;
      int         hi;
      int         r;
      word_type   v;
      word_type   want;
      bit         narrow;
      bit         unloaded_hit;
      lookup_type unused;
      narrow = ($urandom_range(0, 2) == 0);
      for (i = 0; i < span; i++) begin
         // narrow value range makes duplicates likely
         if (narrow) fresh_words[i] = int'($urandom_range(0, 2 * span)) - span;
         else fresh_words[i] = rand_word();
      end
      if (sorted) begin
         for (i = 1; i < span; i++) begin
            v = fresh_words[i];
            j = i - 1;
            while (j >= 0 && fresh_words[j] > v) begin
               fresh_words[j + 1] = fresh_words[j];
               j--;
            end
            fresh_words[j + 1] = v;
         end
      end
      for (i = 0; i < span; i++)
         send_load(index_type'(base + i), fresh_words[i]);
      for (k = 0; k < n_searches; k++) begin
         // stray overwrite inside the region breaks the ordering now and then
         if ($urandom_range(0, 19) == 0)
            send_load(index_type'(base + $urandom_range(0, span - 1)), rand_word());
         r = $urandom_range(0, 99);
         if (r < 50) want = fresh_words[$urandom_range(0, span - 1)];
         else if (r < 70) want = fresh_words[$urandom_range(0, span - 1)]
                                 + ($urandom_range(0, 1) ? 1 : -1);
         else if (r < 90) want = rand_word();
         else want = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         r = $urandom_range(0, 99);
         if (r < 65) begin
            lo = base + $urandom_range(0, span - 1);
            hi = lo + $urandom_range(0, base + span - 1 - lo);
         end else if (r < 80) begin
            lo = base;
            hi = base + span - 1;
         end else if (r < 93) begin
            lo = $urandom_range(0, DEPTH - 1);
            hi = $urandom_range(lo, DEPTH - 1);
            unused = predict_lookup(index_type'(lo), index_type'(hi), want, unloaded_hit);
            if (unloaded_hit) begin
               lo = base;
               hi = base + span - 1;
            end
         end else begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
         end
         send_search(index_type'(lo), index_type'(hi), want);
      end
   endtask

   task automatic test_directed();
      word_type seed_vals [0:7];
      int       i;
      seed_vals = '{32'sh8000_0000, -5, -5, 0, 3, 100, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
      for (i = 0; i < 8; i++) send_load(index_type'(i), seed_vals[i]);
      send_load(index_type'(DEPTH - 1), -1);
      send_search(0, 7, 32'sh8000_0000);
      send_search(0, 7, 32'sh7FFF_FFFF);
      send_search(0, 7, -5);
      send_search(0, 7, 1);
      send_search(0, 7, 101);
      send_search(3, 3, 0);
      send_search(3, 3, 1);
      send_search(0, 0, 32'sh8000_0000);
      send_search(6, 7, 32'sh7FFF_FFFE);
      // empty ranges, down to the widest inverted pair, then the last entry alone
      send_search(5, 4, 3);
      send_search(index_type'(DEPTH - 1), 0, 0);
      send_search(index_type'(DEPTH - 1), index_type'(DEPTH - 1), -1);
      send_search(index_type'(DEPTH - 1), index_type'(DEPTH - 1), 0);
      // out-of-order entry: probes go wherever the compares send them
      send_load(2, 50);
      send_search(0, 7, 50);
      wait_drained();
   endtask

   task automatic test_input_backpressure();
      int k;
      req_idle_on     = 1'b0;
      rsp_idle_on     = 1'b0;
      pressure_cycles = 150;
      for (k = 0; k < 12; k++)
         send_search(0, index_type'($urandom_range(0, 7)), shadow_words[$urandom_range(0, 7)]);
      wait_drained();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_full_table();
      run_session(0, DEPTH, 1'b1, 120);
      wait_drained();
   endtask

   task automatic test_random_sessions();
      int span;
      int r;
      while (items_sent < ITEM_BUDGET) begin
         // some sessions run with no idling on one or both sides
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 99);
         if (r < 80) span = $urandom_range(1, 16);
         else if (r < 95) span = $urandom_range(17, 100);
         else span = $urandom_range(101, 300);
         run_session($urandom_range(0, DEPTH - span), span, $urandom_range(0, 9) != 0,
                     $urandom_range(4, 24));
      end
      wait_drained();
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_cycles > 0) begin
            len             = pressure_cycles;
            pressure_cycles = 0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            len = pick_gap();
         end else begin
            len = 0;
         end
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      lookup_type want_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            note_mismatch("result items with no search pending", 0, 1);
         end else begin
            want_rsp = pending_lookups.pop_front();
            if (rsp_found !== want_rsp.found)
               note_mismatch("found", int'(want_rsp.found), int'(rsp_found));
            if (rsp_position !== want_rsp.position)
               note_mismatch("position", int'(want_rsp.position), int'(rsp_position));
         end
      end
   end

   initial begin
      int i;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = stbs_pkg::CMD_LOAD;
      req_entry_index = '0;
      req_entry_value = '0;
      req_lower_bound = '0;
      req_upper_bound = '0;
      req_target      = '0;
      items_sent      = 0;
      mismatches      = 0;
      pressure_cycles = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      for (i = 0; i < DEPTH; i++) begin
         shadow_words[i] = '0;
         loaded[i]       = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_input_backpressure();
      test_full_table();
      test_random_sessions();

      repeat (20) @(posedge clock);
      if (pending_lookups.size() != 0)
         $display("%0d searches never answered", pending_lookups.size());
      if (mismatches == 0 && pending_lookups.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // timeout far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/core/stbs_pkg.sv
rtl/core/stbs_datapath.sv
rtl/core/stbs_ctrl.sv
rtl/core/sorted_table_binary_search.sv
verif/sorted_table_binary_search_tb.sv
